### hw/rtl/dmerb_pkg.sv
// Package: command codes, result layout and H-bridge drive function for the motor register bank.
`timescale 1ns / 1ps

package dmerb_pkg;

  localparam int COUNT_WIDTH_DEFAULT = 16;
  localparam int DATA_W              = 16;
  localparam int SPEED_W             = 8;
  localparam int MODE_W              = 5;
  localparam int S_TDATA_W           = 24;
  localparam int M_TDATA_W           = 40;

  localparam logic [SPEED_W-1:0] SPEED_MAG_MASK = 8'h7f;
  localparam logic [SPEED_W-1:0] SPEED_SIGN     = 8'h80;
  localparam logic [SPEED_W-1:0] FULL_DUTY      = 8'hff;

  typedef enum logic [MODE_W-1:0] {
    CMD_GET_LED       = 5'd0,
    CMD_SET_LED       = 5'd1,
    CMD_GET_ENC1      = 5'd2,
    CMD_SET_ENC1      = 5'd3,
    CMD_GET_ENC2      = 5'd4,
    CMD_SET_ENC2      = 5'd5,
    CMD_CLEAR_ENC     = 5'd6,
    CMD_LATCH_ENC     = 5'd7,
    CMD_GET_MOTOR1    = 5'd8,
    CMD_SET_MOTOR1    = 5'd9,
    CMD_GET_MOTOR2    = 5'd10,
    CMD_SET_MOTOR2    = 5'd11,
    CMD_GET_M1_REV    = 5'd12,
    CMD_SET_M1_REV    = 5'd13,
    CMD_GET_M2_REV    = 5'd14,
    CMD_SET_M2_REV    = 5'd15,
    CMD_GET_E1_REV    = 5'd16,
    CMD_SET_E1_REV    = 5'd17,
    CMD_GET_E2_REV    = 5'd18,
    CMD_SET_E2_REV    = 5'd19,
    CMD_GET_SWAP      = 5'd20,
    CMD_SET_SWAP      = 5'd21
  } cmd_e;

  // One H-bridge: direction pins and PWM duty.
  typedef struct packed {
    logic               in1;
    logic               in2;
    logic [SPEED_W-1:0] duty;
  } bridge_t;

  // One result, everything the output channel carries.
  typedef struct packed {
    logic              read_valid;
    logic [DATA_W-1:0] read_data;
    logic              led_level;
    bridge_t           bridge_a;
    bridge_t           bridge_b;
  } result_t;

  // Signed speed byte to pins and duty; -128 gives full duty.
  function automatic bridge_t drive_bridge(input logic [SPEED_W-1:0] s, input logic rev);
    bridge_t            b;
    logic               neg;
    logic               pos;
    logic [SPEED_W-1:0] mag;
    neg = s[SPEED_W-1];
    pos = !neg && (s != '0);
    if ((pos && rev) || (neg && !rev)) begin
      b.in1 = 1'b1;
      b.in2 = 1'b0;
    end else if ((s & SPEED_MAG_MASK) == '0) begin
      b.in1 = 1'b0;
      b.in2 = 1'b0;
    end else begin
      b.in1 = 1'b0;
      b.in2 = 1'b1;
    end
    mag = neg ? (SPEED_W'(0) - s) : s;
    b.duty = {mag[SPEED_W-2:0], 1'b0};
    if (s == SPEED_SIGN) begin
      b.duty = FULL_DUTY;
    end
    return b;
  endfunction

endpackage

### hw/rtl/dual_motor_encoder_register_bank_core.sv
// Top level: dual motor / encoder register bank with stream request and result channels.
`timescale 1ns / 1ps

// Register bank for two motors and two encoders. Each request on the slave channel carries a
// command code (tuser) plus a write value and an execute bit (tdata); it is decoded, applied
// to the registers and answered by exactly one result on the master channel, in order. A
// result always shows the LED level and both H-bridge pin/duty settings after the request, plus
// read data for get commands (read_valid in tuser). Requests with execute low, unknown codes and
// set commands give read_valid 0 and read_data 0. Encoder accesses follow the channel swap flag
// and are negated by the per-encoder reverse flags; counts are COUNT_WIDTH bits and reads return
// the low 16 bits. Rate: one request per clock while tready is high; a result is registered
// in the result register, or in the skid entry while that register is held. Requests keep
// flowing while a result waits; tready drops only once both are full.
module dual_motor_encoder_register_bank_core #(
  parameter int COUNT_WIDTH = dmerb_pkg::COUNT_WIDTH_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // [15:0] write_data, [16] execute, [23:17] zero
  input  logic [dmerb_pkg::S_TDATA_W-1:0] s_axis_tdata,
  // [4:0] mode
  input  logic [dmerb_pkg::MODE_W-1:0]    s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // [15:0] read_data, [16] led_level, [17] bridge_a_in1, [18] bridge_a_in2,
  // [26:19] bridge_a_duty, [27] bridge_b_in1, [28] bridge_b_in2,
  // [36:29] bridge_b_duty, [39:37] zero
  output logic [dmerb_pkg::M_TDATA_W-1:0] m_axis_tdata,
  // [0] read_valid
  output logic                            m_axis_tuser
);

  localparam int DW    = dmerb_pkg::DATA_W;
  localparam int SW    = dmerb_pkg::SPEED_W;
  // Wide enough for both a 16-bit read and a COUNT_WIDTH count.
  localparam int EXT_W = (COUNT_WIDTH > DW) ? COUNT_WIDTH : DW;

  // Request fields
  logic [dmerb_pkg::MODE_W-1:0] mode;
  logic signed [DW-1:0]         write_data;
  logic                         execute;
  logic                         flag;
  logic                         accept;

  assign mode       = s_axis_tuser;
  assign write_data = s_axis_tdata[DW-1:0];
  assign execute    = s_axis_tdata[DW];
  assign flag       = (write_data != '0);
  assign accept     = s_axis_tvalid && s_axis_tready;

  // Bank state
  logic                   led_bit,           led_bit_next;
  logic [COUNT_WIDTH-1:0] count_store_a,     count_store_a_next;
  logic [COUNT_WIDTH-1:0] count_store_b,     count_store_b_next;
  logic [SW-1:0]          speed_one,         speed_one_next;
  logic [SW-1:0]          speed_two,         speed_two_next;
  logic                   motor_one_reverse, motor_one_reverse_next;
  logic                   motor_two_reverse, motor_two_reverse_next;
  logic                   count_one_reverse, count_one_reverse_next;
  logic                   count_two_reverse, count_two_reverse_next;
  logic                   channel_swap,      channel_swap_next;
  dmerb_pkg::bridge_t     bridge_a,          bridge_a_next;
  dmerb_pkg::bridge_t     bridge_b,          bridge_b_next;

  // Output stage: result register plus skid entry
  dmerb_pkg::result_t res_next;
  dmerb_pkg::result_t out_res;
  dmerb_pkg::result_t skid_res;
  logic               out_valid;
  logic               skid_valid;

  // Decode helpers
  logic [EXT_W-1:0]       wd_ext;
  logic [COUNT_WIDTH-1:0] wd_count;
  logic [COUNT_WIDTH-1:0] enc1_raw;
  logic [COUNT_WIDTH-1:0] enc2_raw;
  logic [COUNT_WIDTH-1:0] enc1_rd;
  logic [COUNT_WIDTH-1:0] enc2_rd;
  logic [COUNT_WIDTH-1:0] enc1_wr;
  logic [COUNT_WIDTH-1:0] enc2_wr;
  logic [EXT_W-1:0]       enc1_rd_ext;
  logic [EXT_W-1:0]       enc2_rd_ext;
  dmerb_pkg::bridge_t     drive1;
  dmerb_pkg::bridge_t     drive2;

  always_comb begin
    // write value sign extended, then cut to count width
    wd_ext   = EXT_W'(write_data);
    wd_count = wd_ext[COUNT_WIDTH-1:0];

    // encoder 1 sits on store b when swapped
    enc1_raw = channel_swap ? count_store_b : count_store_a;
    enc2_raw = channel_swap ? count_store_a : count_store_b;
    enc1_rd  = count_one_reverse ? (COUNT_WIDTH'(0) - enc1_raw) : enc1_raw;
    enc2_rd  = count_two_reverse ? (COUNT_WIDTH'(0) - enc2_raw) : enc2_raw;
    enc1_wr  = count_one_reverse ? (COUNT_WIDTH'(0) - wd_count) : wd_count;
    enc2_wr  = count_two_reverse ? (COUNT_WIDTH'(0) - wd_count) : wd_count;
    // counts read back zero extended, low 16 bits
    enc1_rd_ext = EXT_W'(enc1_rd);
    enc2_rd_ext = EXT_W'(enc2_rd);

    drive1 = dmerb_pkg::drive_bridge(write_data[SW-1:0], motor_one_reverse);
    drive2 = dmerb_pkg::drive_bridge(write_data[SW-1:0], motor_two_reverse);
  end

  always_comb begin
    led_bit_next           = led_bit;
    count_store_a_next     = count_store_a;
    count_store_b_next     = count_store_b;
    speed_one_next         = speed_one;
    speed_two_next         = speed_two;
    motor_one_reverse_next = motor_one_reverse;
    motor_two_reverse_next = motor_two_reverse;
    count_one_reverse_next = count_one_reverse;
    count_two_reverse_next = count_two_reverse;
    channel_swap_next      = channel_swap;
    bridge_a_next          = bridge_a;
    bridge_b_next          = bridge_b;
    res_next.read_valid    = 1'b0;
    res_next.read_data     = '0;

    if (execute) begin
      case (dmerb_pkg::cmd_e'(mode))
        dmerb_pkg::CMD_GET_LED: begin
          res_next.read_valid = 1'b1;
          res_next.read_data  = DW'(led_bit);
        end
        dmerb_pkg::CMD_SET_LED: led_bit_next = flag;
        dmerb_pkg::CMD_GET_ENC1: begin
          res_next.read_valid = 1'b1;
          res_next.read_data  = enc1_rd_ext[DW-1:0];
        end
        dmerb_pkg::CMD_SET_ENC1: begin
          if (channel_swap) count_store_b_next = enc1_wr;
          else              count_store_a_next = enc1_wr;
        end
        dmerb_pkg::CMD_GET_ENC2: begin
          res_next.read_valid = 1'b1;
          res_next.read_data  = enc2_rd_ext[DW-1:0];
        end
        dmerb_pkg::CMD_SET_ENC2: begin
          if (channel_swap) count_store_a_next = enc2_wr;
          else              count_store_b_next = enc2_wr;
        end
        dmerb_pkg::CMD_CLEAR_ENC: begin
          count_store_a_next = '0;
          count_store_b_next = '0;
        end
        dmerb_pkg::CMD_LATCH_ENC: ;
        dmerb_pkg::CMD_GET_MOTOR1: begin
          res_next.read_valid = 1'b1;
          res_next.read_data  = DW'(signed'(speed_one));
        end
        dmerb_pkg::CMD_SET_MOTOR1: begin
          speed_one_next = write_data[SW-1:0];
          if (channel_swap) bridge_b_next = drive1;
          else              bridge_a_next = drive1;
        end
        dmerb_pkg::CMD_GET_MOTOR2: begin
          res_next.read_valid = 1'b1;
          res_next.read_data  = DW'(signed'(speed_two));
        end
        dmerb_pkg::CMD_SET_MOTOR2: begin
          speed_two_next = write_data[SW-1:0];
          if (channel_swap) bridge_a_next = drive2;
          else              bridge_b_next = drive2;
        end
        dmerb_pkg::CMD_GET_M1_REV: begin
          res_next.read_valid = 1'b1;
          res_next.read_data  = DW'(motor_one_reverse);
        end
        dmerb_pkg::CMD_SET_M1_REV: motor_one_reverse_next = flag;
        dmerb_pkg::CMD_GET_M2_REV: begin
          res_next.read_valid = 1'b1;
          res_next.read_data  = DW'(motor_two_reverse);
        end
        dmerb_pkg::CMD_SET_M2_REV: motor_two_reverse_next = flag;
        dmerb_pkg::CMD_GET_E1_REV: begin
          res_next.read_valid = 1'b1;
          res_next.read_data  = DW'(count_one_reverse);
        end
        dmerb_pkg::CMD_SET_E1_REV: count_one_reverse_next = flag;
        dmerb_pkg::CMD_GET_E2_REV: begin
          res_next.read_valid = 1'b1;
          res_next.read_data  = DW'(count_two_reverse);
        end
        dmerb_pkg::CMD_SET_E2_REV: count_two_reverse_next = flag;
        dmerb_pkg::CMD_GET_SWAP: begin
          res_next.read_valid = 1'b1;
          res_next.read_data  = DW'(channel_swap);
        end
        dmerb_pkg::CMD_SET_SWAP: channel_swap_next = flag;
        default: ;  // unknown code: no effect
      endcase
    end

    // result shows levels after this request
    res_next.led_level = led_bit_next;
    res_next.bridge_a  = bridge_a_next;
    res_next.bridge_b  = bridge_b_next;
  end

  // State updates only on an accepted request
  always_ff @(posedge clk) begin
    if (rst) begin
      led_bit           <= 1'b1;
      count_store_a     <= '0;
      count_store_b     <= '0;
      speed_one         <= '0;
      speed_two         <= '0;
      motor_one_reverse <= 1'b1;
      motor_two_reverse <= 1'b1;
      count_one_reverse <= 1'b0;
      count_two_reverse <= 1'b0;
      channel_swap      <= 1'b1;
      bridge_a          <= '0;
      bridge_b          <= '0;
    end else if (accept) begin
      led_bit           <= led_bit_next;
      count_store_a     <= count_store_a_next;
      count_store_b     <= count_store_b_next;
      speed_one         <= speed_one_next;
      speed_two         <= speed_two_next;
      motor_one_reverse <= motor_one_reverse_next;
      motor_two_reverse <= motor_two_reverse_next;
      count_one_reverse <= count_one_reverse_next;
      count_two_reverse <= count_two_reverse_next;
      channel_swap      <= channel_swap_next;
      bridge_a          <= bridge_a_next;
      bridge_b          <= bridge_b_next;
    end
  end

  // Result register with one skid entry; skid drains first to keep order
  assign s_axis_tready = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || m_axis_tready) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= accept;
      end
    end else if (accept) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || m_axis_tready) begin
      if (skid_valid) begin
        out_res <= skid_res;
      end else if (accept) begin
        out_res <= res_next;
      end
    end else if (accept) begin
      skid_res <= res_next;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser  = out_res.read_valid;
  assign m_axis_tdata  = {3'b000,
                          out_res.bridge_b.duty, out_res.bridge_b.in2, out_res.bridge_b.in1,
                          out_res.bridge_a.duty, out_res.bridge_a.in2, out_res.bridge_a.in1,
                          out_res.led_level, out_res.read_data};

  // Skid entry is only ever used behind a full result register
  assert property (@(posedge clk) disable iff (rst) skid_valid |-> out_valid)
    else $error("skid entry holds a result while the result register is empty");

  // A request taken while the result waits must land in the skid entry
  assert property (@(posedge clk) disable iff (rst)
    (accept && out_valid && !m_axis_tready) |=> skid_valid)
    else $error("request accepted under backpressure was not captured");

  // A bridge is never driven with both direction pins high
  assert property (@(posedge clk) disable iff (rst)
    !(bridge_a.in1 && bridge_a.in2) && !(bridge_b.in1 && bridge_b.in2))
    else $error("H-bridge direction pins both high");

  // A request with execute low leaves the bank untouched
  assert property (@(posedge clk) disable iff (rst)
    (accept && !execute) |=> ($stable(count_store_a) && $stable(count_store_b) &&
                              $stable(channel_swap) && $stable(led_bit)))
    else $error("non-executed request changed bank state");

endmodule
